[src/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands used by the pbt_checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is high
`define ASSERT_IMPLY(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication, switched off while reset is high
`define ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("%m: check failed");

// Next-cycle implication that also holds through reset
`define ASSERT_NEXT_ALWAYS(name, clk, ante, cons) \
   name: assert property (@(posedge clk) (ante) |=> (cons)) \
      else $error("%m: check failed");

`endif

[src/pbt_pkg.sv]
// ----------------------------------------------------------------------------
// pbt_pkg
// Shared types and constants of the palette pixel blitter.
// ----------------------------------------------------------------------------
package pbt_pkg;

   // Sizing
   localparam int unsigned PALETTE_ENTRIES   = 256;
   localparam int unsigned MAX_CANVAS_WIDTH  = 256;
   localparam int unsigned MAX_CANVAS_HEIGHT = 256;

   localparam int unsigned INDEX_W = 8;
   localparam int unsigned COORD_W = 8;
   localparam int unsigned CHAN_W  = 8;
   localparam int unsigned RGB_W   = 3 * CHAN_W;
   localparam int unsigned DIM_W   = 9;
   localparam int unsigned ADDR_W  = 16;
   localparam int unsigned PROD_W  = COORD_W + DIM_W;
   localparam int unsigned PAL_AW  = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;

   // Saturation limits, expressed in register width
   localparam int unsigned DIM_MAX    = (1 << DIM_W) - 1;
   localparam int unsigned WIDTH_CAP  = (MAX_CANVAS_WIDTH > DIM_MAX) ? DIM_MAX
                                                                      : MAX_CANVAS_WIDTH;
   localparam int unsigned HEIGHT_CAP = (MAX_CANVAS_HEIGHT > DIM_MAX) ? DIM_MAX
                                                                       : MAX_CANVAS_HEIGHT;
   localparam logic [DIM_W-1:0] WIDTH_CAP_V  = DIM_W'(WIDTH_CAP);
   localparam logic [DIM_W-1:0] HEIGHT_CAP_V = DIM_W'(HEIGHT_CAP);

   // Index range of the palette, one bit wider than an index
   localparam logic [INDEX_W:0] PAL_LIMIT_V = (INDEX_W + 1)'(PALETTE_ENTRIES);

   // Reset value of both canvas registers
   localparam logic [DIM_W-1:0] DIM_RESET = DIM_W'(256);

   // Disposal method "restore to background"
   localparam logic [2:0] DISPOSAL_RESTORE_BG = 3'd2;

   typedef enum logic {
      CMD_LOAD = 1'b0,
      CMD_DRAW = 1'b1
   } cmd_type;

   typedef enum logic {
      CSR_CANVAS_WIDTH  = 1'b0,
      CSR_CANVAS_HEIGHT = 1'b1
   } csr_index_type;

   // Canvas settings as seen by the pipeline
   typedef struct packed {
      logic [DIM_W-1:0] width;
      logic [DIM_W-1:0] height;
   } canvas_type;

   // First stage contents handed to the address/compose stages
   typedef struct packed {
      logic [COORD_W-1:0] row;
      logic [COORD_W-1:0] column;
      logic [DIM_W-1:0]   width;
      logic               force_black;
   } stage1_type;

endpackage

[src/pbt_req_if.sv]
// ----------------------------------------------------------------------------
// pbt_req_if
// Request channel: palette loads and pixel draws.
// ----------------------------------------------------------------------------
interface pbt_req_if;
   logic       valid;
   logic       ready;
   logic       cmd;
   logic [7:0] color_index;
   logic [7:0] load_red;
   logic [7:0] load_green;
   logic [7:0] load_blue;
   logic [7:0] row;
   logic [7:0] column;
   logic [7:0] transparent_index;
   logic       has_transparency;
   logic [2:0] disposal_method;

   modport source (
      output valid, cmd, color_index, load_red, load_green, load_blue, row, column,
             transparent_index, has_transparency, disposal_method,
      input  ready
   );

   modport sink (
      input  valid, cmd, color_index, load_red, load_green, load_blue, row, column,
             transparent_index, has_transparency, disposal_method,
      output ready
   );
endinterface

[src/pbt_rsp_if.sv]
// ----------------------------------------------------------------------------
// pbt_rsp_if
// Response channel: one framebuffer write per drawn pixel.
// ----------------------------------------------------------------------------
interface pbt_rsp_if;
   logic        valid;
   logic        ready;
   logic [15:0] pixel_address;
   logic [7:0]  out_red;
   logic [7:0]  out_green;
   logic [7:0]  out_blue;

   modport source (
      output valid, pixel_address, out_red, out_green, out_blue,
      input  ready
   );

   modport sink (
      input  valid, pixel_address, out_red, out_green, out_blue,
      output ready
   );
endinterface

[src/palette_pixel_blit_transparent.sv]
// An accepted draw passes the stage 1, 2 and 3 registers to its output write.
// Throughput: one request per cycle while the output is not stalled; set by
// the three-stage pipeline, one palette RAM port for reads and one for writes.
// Reset clears all pipeline valids and sets both canvas registers to 256;
// palette contents are not cleared and read as undefined until loaded.
// ----------------------------------------------------------------------------
// palette_pixel_blit_transparent
// Converts indexed-colour pixels into RGB888 framebuffer writes with GIF
// transparency handling and canvas clipping.
// ----------------------------------------------------------------------------
module palette_pixel_blit_transparent import pbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   pbt_req_if.sink          req_bus,
   pbt_rsp_if.source        rsp_bus,
   input  logic             csr_wr_en,
   input  logic             csr_index,
   input  logic [DIM_W-1:0] csr_wdata
);

   logic [DIM_W-1:0] width_ff, width_in;
   logic [DIM_W-1:0] height_ff, height_in;
   canvas_type       canvas;
   logic             s1_valid, s2_ready;
   stage1_type       s1_data;
   logic [RGB_W-1:0] s1_rgb;

   // Canvas registers
   always_comb begin
      width_in  = width_ff;
      height_in = height_ff;
      if (csr_wr_en) begin
         case (csr_index_type'(csr_index))
            CSR_CANVAS_WIDTH:  width_in  = csr_wdata;
            CSR_CANVAS_HEIGHT: height_in = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff  <= DIM_RESET;
         height_ff <= DIM_RESET;
      end else begin
         width_ff  <= width_in;
         height_ff <= height_in;
      end
   end

   assign canvas.width  = width_ff;
   assign canvas.height = height_ff;

   pbt_decode u_decode (
      .clock    (clock),
      .reset    (reset),
      .req_bus  (req_bus),
      .canvas   (canvas),
      .s1_valid (s1_valid),
      .s1_data  (s1_data),
      .s1_rgb   (s1_rgb),
      .s2_ready (s2_ready)
   );

   pbt_compose u_compose (
      .clock    (clock),
      .reset    (reset),
      .s1_valid (s1_valid),
      .s1_data  (s1_data),
      .s1_rgb   (s1_rgb),
      .s2_ready (s2_ready),
      .rsp_bus  (rsp_bus)
   );

endmodule

[src/pbt_ram.sv]
// ----------------------------------------------------------------------------
// pbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module pbt_ram #(
   parameter int unsigned WIDTH = 24,
   parameter int unsigned DEPTH = 256
) (
   input  logic                                      clock,
   input  logic                                      wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                          wr_data,
   input  logic                                      rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                          rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Read port, data held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

[src/pbt_decode.sv]
// ----------------------------------------------------------------------------
// pbt_decode
// First stage: command decode, palette write/read, canvas bounds and
// transparency decision. Dropped pixels and loads leave stage 1 empty but
// never stall the request side.
// ----------------------------------------------------------------------------
module pbt_decode import pbt_pkg::*; (
   input  logic               clock,
   input  logic               reset,
   pbt_req_if.sink            req_bus,
   input  canvas_type         canvas,
   output logic               s1_valid,
   output stage1_type         s1_data,
   output logic [RGB_W-1:0]   s1_rgb,
   input  logic               s2_ready
);

   logic               s1_valid_ff, s1_valid_in;
   stage1_type         s1_data_ff, s1_data_in;
   logic               s1_ready;
   logic               accept;
   logic               is_draw, is_load;
   logic [DIM_W-1:0]   width_sat, height_sat;
   logic               on_canvas, in_range, idx_match, skip;
   logic               pal_wr_en, pal_rd_en;

   assign s1_ready      = !s1_valid_ff || s2_ready;
   assign req_bus.ready = s1_ready;
   assign accept        = req_bus.valid && s1_ready;
   assign is_draw       = (req_bus.cmd == CMD_DRAW);
   assign is_load       = (req_bus.cmd == CMD_LOAD);

   // Saturate canvas size and test bounds
   always_comb begin
      width_sat  = (canvas.width  > WIDTH_CAP_V)  ? WIDTH_CAP_V  : canvas.width;
      height_sat = (canvas.height > HEIGHT_CAP_V) ? HEIGHT_CAP_V : canvas.height;
      on_canvas  = ({1'b0, req_bus.column} < width_sat) &&
                   ({1'b0, req_bus.row} < height_sat);
   end

   // Transparency: skip or paint black
   always_comb begin
      in_range  = ({1'b0, req_bus.color_index} < PAL_LIMIT_V);
      idx_match = (req_bus.color_index == req_bus.transparent_index);
      skip      = idx_match && req_bus.has_transparency &&
                  (req_bus.disposal_method != DISPOSAL_RESTORE_BG);
   end

   // Palette access
   assign pal_wr_en = accept && is_load && in_range;
   assign pal_rd_en = accept && is_draw;

   pbt_ram #(
      .WIDTH (RGB_W),
      .DEPTH (PALETTE_ENTRIES)
   ) u_palette (
      .clock   (clock),
      .wr_en   (pal_wr_en),
      .wr_addr (req_bus.color_index[PAL_AW-1:0]),
      .wr_data ({req_bus.load_red, req_bus.load_green, req_bus.load_blue}),
      .rd_en   (pal_rd_en),
      .rd_addr (req_bus.color_index[PAL_AW-1:0]),
      .rd_data (s1_rgb)
   );

   // Stage 1 next values
   always_comb begin
      s1_valid_in             = accept && is_draw && on_canvas && !skip;
      s1_data_in.row          = req_bus.row;
      s1_data_in.column       = req_bus.column;
      s1_data_in.width        = width_sat;
      s1_data_in.force_black  = idx_match || !in_range;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (s1_ready) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_ready) begin
         s1_data_ff <= s1_data_in;
      end
   end

   assign s1_valid = s1_valid_ff;
   assign s1_data  = s1_data_ff;

endmodule

[src/pbt_compose.sv]
// ----------------------------------------------------------------------------
// pbt_compose
// Second and third stages: row times width and colour select, then add the
// column. The third stage is the output register.
// ----------------------------------------------------------------------------
module pbt_compose import pbt_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             s1_valid,
   input  stage1_type       s1_data,
   input  logic [RGB_W-1:0] s1_rgb,
   output logic             s2_ready,
   pbt_rsp_if.source        rsp_bus
);

   logic                s2_valid_ff, s2_valid_in;
   logic [PROD_W-1:0]   s2_prod_ff, s2_prod_in;
   logic [COORD_W-1:0]  s2_column_ff;
   logic [RGB_W-1:0]    s2_rgb_ff, s2_rgb_in;
   logic                s3_valid_ff, s3_ready;
   logic [ADDR_W-1:0]   s3_addr_ff, s3_addr_in;
   logic [RGB_W-1:0]    s3_rgb_ff;
   logic [PROD_W:0]     addr_sum;

   assign s3_ready = !s3_valid_ff || rsp_bus.ready;
   assign s2_ready = !s2_valid_ff || s3_ready;

   // Stage 2: multiply and colour select
   always_comb begin
      s2_valid_in = s1_valid;
      s2_prod_in  = PROD_W'(s1_data.row * s1_data.width);
      s2_rgb_in   = s1_data.force_black ? '0 : s1_rgb;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else if (s2_ready) begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (s2_ready) begin
         s2_prod_ff   <= s2_prod_in;
         s2_column_ff <= s1_data.column;
         s2_rgb_ff    <= s2_rgb_in;
      end
   end

   // Stage 3: final address, wrapped to the address width
   always_comb begin
      addr_sum   = {1'b0, s2_prod_ff} + (PROD_W + 1)'(s2_column_ff);
      s3_addr_in = addr_sum[ADDR_W-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else if (s3_ready) begin
         s3_valid_ff <= s2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (s3_ready) begin
         s3_addr_ff <= s3_addr_in;
         s3_rgb_ff  <= s2_rgb_ff;
      end
   end

   assign rsp_bus.valid         = s3_valid_ff;
   assign rsp_bus.pixel_address = s3_addr_ff;
   assign rsp_bus.out_red       = s3_rgb_ff[RGB_W-1 -: CHAN_W];
   assign rsp_bus.out_green     = s3_rgb_ff[2*CHAN_W-1 -: CHAN_W];
   assign rsp_bus.out_blue      = s3_rgb_ff[CHAN_W-1:0];

endmodule

[src/pbt_checker.sv]
// ----------------------------------------------------------------------------
// pbt_checker
// Port-level checks of the blitter: reset, ready chain, latency, output hold.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module pbt_checker import pbt_pkg::*; (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_cmd,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_pixel_address,
   input logic [7:0]  rsp_out_red,
   input logic [7:0]  rsp_out_green,
   input logic [7:0]  rsp_out_blue
);

   logic draw_accept;

   assign draw_accept = req_valid && req_ready && (req_cmd == CMD_DRAW);

   // Reset empties the output register
   `ASSERT_NEXT_ALWAYS(a_reset_clears, clock, reset, !rsp_valid)

   // With nothing waiting at the output every stage can move, so requests flow
   `ASSERT_IMPLY(a_ready_when_empty, clock, reset, !rsp_valid, req_ready)

   // A fresh write comes from an accepted draw via the stage 1, 2 and 3 registers
   `ASSERT_IMPLY(a_rise_latency, clock, reset, $rose(rsp_valid), $past(draw_accept, 3))

   // A stalled write holds
   `ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_address) && $stable(rsp_out_red) && $stable(rsp_out_green) && $stable(rsp_out_blue))

endmodule

bind palette_pixel_blit_transparent pbt_checker u_pbt_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_bus.valid),
   .req_ready         (req_bus.ready),
   .req_cmd           (req_bus.cmd),
   .rsp_valid         (rsp_bus.valid),
   .rsp_ready         (rsp_bus.ready),
   .rsp_pixel_address (rsp_bus.pixel_address),
   .rsp_out_red       (rsp_bus.out_red),
   .rsp_out_green     (rsp_bus.out_green),
   .rsp_out_blue      (rsp_bus.out_blue)
);

[test/palette_pixel_blit_transparent_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// palette_pixel_blit_transparent_tb
// Self-checking bench for the palette pixel blitter. A directed table covers
// the field extremes, transparency and disposal rules and canvas clipping
// under several canvas settings. Random frames follow: palette loads, then a
// line of pixels sharing one transparent index, plus stray requests. Each
// write is checked against its table entry or a local palette/canvas model.
// ----------------------------------------------------------------------------
module palette_pixel_blit_transparent_tb;
   import pbt_pkg::*;

   localparam int HALF_PERIOD     = 5;
   localparam int PIPE_DRAIN      = 6;   // drain margin for the three-stage pipeline
   localparam int WATCHDOG_LIMIT  = 400;
   localparam int NUM_PHASES      = 8;
   localparam int ITEMS_PER_PHASE = 190;
   localparam int NUM_DIRECTED    = 28;

   typedef struct packed {
      cmd_type    cmd;
      logic [7:0] color_index;
      logic [7:0] load_red;
      logic [7:0] load_green;
      logic [7:0] load_blue;
      logic [7:0] row;
      logic [7:0] column;
      logic [7:0] transparent_index;
      logic       has_transparency;
      logic [2:0] disposal_method;
   } pixel_req_type;

   typedef struct packed {
      logic [15:0] pixel_address;
      logic [7:0]  red;
      logic [7:0]  green;
      logic [7:0]  blue;
   } fb_write_type;

   typedef enum logic {
      STEP_REQ,
      STEP_CSR
   } step_kind_type;

   // how a directed request is checked
   typedef enum logic [1:0] {
      CHECK_MODEL,
      CHECK_SILENT,
      CHECK_TYPED
   } check_type;

   typedef struct packed {
      step_kind_type kind;
      csr_index_type csr_sel;
      logic [8:0]    csr_value;
      pixel_req_type req;
      check_type     check;
      fb_write_type  write;
   } step_type;

   // Directed table: palette entries 0, 1, 128 and 255 are loaded first
   localparam step_type DIRECTED_STEPS [NUM_DIRECTED] = '{
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_LOAD, 8'd0, 8'hff, 8'h00, 8'h00, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
        CHECK_SILENT, '0},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_LOAD, 8'd255, 8'h00, 8'hff, 8'h00, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
        CHECK_SILENT, '0},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_LOAD, 8'd1, 8'h12, 8'h34, 8'h56, 8'd0, 8'd0, 8'd0, 1'b0, 3'd0},
        CHECK_SILENT, '0},
      // load carrying draw fields, which must be ignored
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_LOAD, 8'd128, 8'ha5, 8'h5a, 8'hc3, 8'hff, 8'hff, 8'h80, 1'b1, 3'd7},
        CHECK_SILENT, '0},
      // corners of the full canvas
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 3'd0},
        CHECK_TYPED, '{16'h0000, 8'hff, 8'h00, 8'h00}},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 1'b1, 3'd7},
        CHECK_TYPED, '{16'hffff, 8'h00, 8'hff, 8'h00}},
      // transparent pixel skipped
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd1, 8'd0, 8'd0, 8'd0, 8'd10, 8'd20, 8'd1, 1'b1, 3'd0},
        CHECK_SILENT, '0},
      // transparent index under restore-to-background: black
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd1, 8'd0, 8'd0, 8'd0, 8'd10, 8'd21, 8'd1, 1'b1,
          DISPOSAL_RESTORE_BG},
        CHECK_TYPED, '{16'h0a15, 8'h00, 8'h00, 8'h00}},
      // transparent index with the flag off: black
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd1, 8'd0, 8'd0, 8'd0, 8'd10, 8'd22, 8'd1, 1'b0, 3'd5},
        CHECK_TYPED, '{16'h0a16, 8'h00, 8'h00, 8'h00}},
      // draw carrying load fields, which must be ignored
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd128, 8'hff, 8'hff, 8'hff, 8'd3, 8'd4, 8'd0, 1'b1, 3'd3},
        CHECK_TYPED, '{16'h0304, 8'ha5, 8'h5a, 8'hc3}},
      // one-pixel canvas
      '{STEP_CSR, CSR_CANVAS_WIDTH, 9'd1, '0, CHECK_SILENT, '0},
      '{STEP_CSR, CSR_CANVAS_HEIGHT, 9'd1, '0, CHECK_SILENT, '0},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 3'd0},
        CHECK_TYPED, '{16'h0000, 8'hff, 8'h00, 8'h00}},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd255, 1'b0, 3'd0},
        CHECK_SILENT, '0},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd1, 8'd0, 8'd255, 1'b0, 3'd0},
        CHECK_SILENT, '0},
      // zero width suppresses everything
      '{STEP_CSR, CSR_CANVAS_WIDTH, 9'd0, '0, CHECK_SILENT, '0},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 3'd0},
        CHECK_SILENT, '0},
      // oversized width saturates, zero height suppresses
      '{STEP_CSR, CSR_CANVAS_WIDTH, 9'd511, '0, CHECK_SILENT, '0},
      '{STEP_CSR, CSR_CANVAS_HEIGHT, 9'd0, '0, CHECK_SILENT, '0},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd255, 1'b0, 3'd0},
        CHECK_SILENT, '0},
      // both saturated: far corner is still reachable
      '{STEP_CSR, CSR_CANVAS_HEIGHT, 9'd511, '0, CHECK_SILENT, '0},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd255, 8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 1'b0, 3'd0},
        CHECK_TYPED, '{16'hffff, 8'h00, 8'hff, 8'h00}},
      // odd canvas: last pixel inside, first ones outside
      '{STEP_CSR, CSR_CANVAS_WIDTH, 9'd100, '0, CHECK_SILENT, '0},
      '{STEP_CSR, CSR_CANVAS_HEIGHT, 9'd50, '0, CHECK_SILENT, '0},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd1, 8'd0, 8'd0, 8'd0, 8'd49, 8'd99, 8'd0, 1'b1, 3'd0},
        CHECK_TYPED, '{16'h1387, 8'h12, 8'h34, 8'h56}},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd1, 8'd0, 8'd0, 8'd0, 8'd50, 8'd0, 8'd0, 1'b1, 3'd0},
        CHECK_SILENT, '0},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd1, 8'd0, 8'd0, 8'd0, 8'd0, 8'd100, 8'd0, 1'b1, 3'd0},
        CHECK_SILENT, '0},
      '{STEP_REQ, CSR_CANVAS_WIDTH, 9'd0,
        '{CMD_DRAW, 8'd128, 8'd0, 8'd0, 8'd0, 8'd7, 8'd13, 8'd7, 1'b1, 3'd6},
        CHECK_MODEL, '0}
   };

   logic clock;
   logic reset;
   logic csr_wr_en;
   logic csr_index;
   logic [DIM_W-1:0] csr_wdata;

   pbt_req_if req_bus ();
   pbt_rsp_if rsp_bus ();

   palette_pixel_blit_transparent dut (
      .clock     (clock),
      .reset     (reset),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   // Local copy of the palette and canvas registers
   logic [23:0]  colour_lut [PALETTE_ENTRIES];
   bit           lut_loaded [PALETTE_ENTRIES];
   logic [7:0]   loaded_indices [$];
   logic [8:0]   canvas_w = DIM_RESET;
   logic [8:0]   canvas_h = DIM_RESET;

   fb_write_type pending_writes [$];
   int           bad_writes = 0;
   bit           req_calm = 1'b0;
   bit           rsp_calm = 1'b0;
   bit           rsp_taken = 1'b0;
   int           rsp_hold = 0;

   initial clock = 1'b0;
   always #(HALF_PERIOD) clock = ~clock;

   function automatic int canvas_extent(input logic [8:0] value, input int cap);
      return (value > cap) ? cap : int'(value);
   endfunction

   // Applies one request to the local state; returns 1 when a write is due
   function automatic bit blit_pixel(input pixel_req_type r, output fb_write_type w);
      int          eff_w;
      int          eff_h;
      logic [23:0] rgb;
      w = '0;
      if (r.cmd == CMD_LOAD) begin
         colour_lut[r.color_index] = {r.load_red, r.load_green, r.load_blue};
         if (!lut_loaded[r.color_index]) begin
            lut_loaded[r.color_index] = 1'b1;
            loaded_indices.push_back(r.color_index);
         end
         return 1'b0;
      end
      eff_w = canvas_extent(canvas_w, MAX_CANVAS_WIDTH);
      eff_h = canvas_extent(canvas_h, MAX_CANVAS_HEIGHT);
      if (int'(r.column) >= eff_w || int'(r.row) >= eff_h) return 1'b0;
      if (r.color_index == r.transparent_index) begin
         if (r.has_transparency && r.disposal_method != DISPOSAL_RESTORE_BG) return 1'b0;
         rgb = '0;
      end else begin
         rgb = colour_lut[r.color_index];
      end
      w.pixel_address = 16'(int'(r.row) * eff_w + int'(r.column));
      {w.red, w.green, w.blue} = rgb;
      return 1'b1;
   endfunction

   function automatic logic [7:0] pick_loaded();
      return loaded_indices[$urandom_range(0, loaded_indices.size() - 1)];
   endfunction

   function automatic pixel_req_type random_request();
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(pixel_req_type)-1:0];
   endfunction

   // Sends one request, then records what it should produce
   task automatic send_request(input pixel_req_type r, input check_type chk,
                               input fb_write_type typed);
      int           gap;
      bit           due;
      fb_write_type w;
      gap = req_calm ? 0 : $urandom_range(0, 9);
      if (gap != 0) begin
         req_bus.valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_bus.cmd               = r.cmd;
      req_bus.color_index       = r.color_index;
      req_bus.load_red          = r.load_red;
      req_bus.load_green        = r.load_green;
      req_bus.load_blue         = r.load_blue;
      req_bus.row               = r.row;
      req_bus.column            = r.column;
      req_bus.transparent_index = r.transparent_index;
      req_bus.has_transparency  = r.has_transparency;
      req_bus.disposal_method   = r.disposal_method;
      req_bus.valid             = 1'b1;
      do @(posedge clock); while (!req_bus.ready);
      due = blit_pixel(r, w);
      if (chk == CHECK_TYPED) begin
         pending_writes.push_back(typed);
      end else if (chk == CHECK_MODEL && due) begin
         pending_writes.push_back(w);
      end
      @(negedge clock);
   endtask

   // Nothing in flight: all writes seen and the pipeline flushed
   task automatic wait_for_idle();
      req_bus.valid = 1'b0;
      while (pending_writes.size() != 0) @(negedge clock);
      repeat (PIPE_DRAIN) @(negedge clock);
   endtask

   task automatic write_canvas(input csr_index_type sel, input logic [8:0] value);
      csr_wr_en = 1'b1;
      csr_index = sel;
      csr_wdata = value;
      @(negedge clock);
      csr_wr_en = 1'b0;
      if (sel == CSR_CANVAS_WIDTH) begin
         canvas_w = value;
      end else begin
         canvas_h = value;
      end
   endtask

   // One frame: a few palette loads, then a line of pixels with stray requests
   task automatic play_frame(inout int sent);
      int            eff_w;
      int            eff_h;
      int            n_loads;
      int            n_pixels;
      logic [7:0]    tidx;
      logic [7:0]    line_row;
      logic [7:0]    left;
      logic          has_t;
      logic [2:0]    disp;
      pixel_req_type r;
      eff_w = canvas_extent(canvas_w, MAX_CANVAS_WIDTH);
      eff_h = canvas_extent(canvas_h, MAX_CANVAS_HEIGHT);
      n_loads = $urandom_range(0, 6);
      repeat (n_loads) begin
         r = random_request();
         r.cmd = CMD_LOAD;
         send_request(r, CHECK_MODEL, '0);
         sent++;
      end
      tidx  = ($urandom_range(0, 9) < 7) ? pick_loaded() : 8'($urandom);
      has_t = 1'($urandom_range(0, 1));
      disp  = ($urandom_range(0, 3) == 0) ? DISPOSAL_RESTORE_BG : 3'($urandom);
      line_row = (eff_h > 0 && $urandom_range(0, 9) != 0) ?
                 8'($urandom_range(0, eff_h - 1)) : 8'($urandom);
      left     = (eff_w > 0 && $urandom_range(0, 9) != 0) ?
                 8'($urandom_range(0, eff_w - 1)) : 8'($urandom);
      n_pixels = $urandom_range(1, 24);
      for (int k = 0; k < n_pixels; k++) begin
         r = random_request();
         if ($urandom_range(0, 9) != 0) begin
            r.cmd               = CMD_DRAW;
            r.row               = line_row;
            r.column            = left + 8'(k);
            r.transparent_index = tidx;
            r.has_transparency  = has_t;
            r.disposal_method   = disp;
            r.color_index       = ($urandom_range(0, 4) == 0) ? tidx : pick_loaded();
         end
         // never look up a palette entry that has not been loaded
         if (r.cmd == CMD_DRAW && !lut_loaded[r.color_index]) r.color_index = pick_loaded();
         send_request(r, CHECK_MODEL, '0);
         sent++;
      end
   endtask

   // Write checker
   always @(posedge clock) begin
      fb_write_type got;
      fb_write_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         rsp_taken = 1'b1;
         got = '{rsp_bus.pixel_address, rsp_bus.out_red, rsp_bus.out_green,
                 rsp_bus.out_blue};
         if (pending_writes.size() == 0) begin
            $display("%0t: unexpected write, addr %h rgb %h %h %h", $time,
                     got.pixel_address, got.red, got.green, got.blue);
            bad_writes++;
         end else begin
            want = pending_writes.pop_front();
            if (got !== want) begin
               $display("%0t: write mismatch, expected addr %h rgb %h %h %h, got addr %h rgb %h %h %h",
                        $time, want.pixel_address, want.red, want.green, want.blue,
                        got.pixel_address, got.red, got.green, got.blue);
               bad_writes++;
            end
         end
      end
   end

   // Write sink: random stall after each accepted write
   always @(negedge clock) begin
      if (rsp_taken) begin
         rsp_taken = 1'b0;
         rsp_hold = rsp_calm ? 0 : $urandom_range(0, 9);
      end
      if (rsp_hold != 0) begin
         rsp_bus.ready = 1'b0;
         rsp_hold--;
      end else begin
         rsp_bus.ready = 1'b1;
      end
   end

   // Watchdog on accepted traffic
   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < WATCHDOG_LIMIT) begin
         @(posedge clock);
         if (reset || csr_wr_en || (req_bus.valid && req_bus.ready) ||
             (rsp_bus.valid && rsp_bus.ready)) begin
            quiet_cycles = 0;
         end else begin
            quiet_cycles++;
         end
      end
      $display("%0t: nothing accepted for %0d cycles", $time, quiet_cycles);
      $display("FAILED: results differ");
      $finish;
   end

   // Stimulus
   initial begin
      int         phase_sent;
      logic [8:0] w_set;
      logic [8:0] h_set;
      reset                     = 1'b1;
      csr_wr_en                 = 1'b0;
      csr_index                 = CSR_CANVAS_WIDTH;
      csr_wdata                 = '0;
      rsp_bus.ready             = 1'b0;
      req_bus.valid             = 1'b0;
      req_bus.cmd               = CMD_LOAD;
      req_bus.color_index       = '0;
      req_bus.load_red          = '0;
      req_bus.load_green        = '0;
      req_bus.load_blue         = '0;
      req_bus.row               = '0;
      req_bus.column            = '0;
      req_bus.transparent_index = '0;
      req_bus.has_transparency  = 1'b0;
      req_bus.disposal_method   = '0;
      for (int i = 0; i < PALETTE_ENTRIES; i++) lut_loaded[i] = 1'b0;
      repeat (2) @(negedge clock);
      reset = 1'b0;

      // directed table
      foreach (DIRECTED_STEPS[i]) begin
         if (DIRECTED_STEPS[i].kind == STEP_CSR) begin
            wait_for_idle();
            write_canvas(DIRECTED_STEPS[i].csr_sel, DIRECTED_STEPS[i].csr_value);
         end else begin
            send_request(DIRECTED_STEPS[i].req, DIRECTED_STEPS[i].check,
                         DIRECTED_STEPS[i].write);
         end
      end

      // random frames under a range of canvas settings
      for (int phase = 0; phase < NUM_PHASES; phase++) begin
         case (phase)
            0: begin
               w_set = 9'd256;
               h_set = 9'd256;
            end
            1: begin
               w_set = 9'd1;
               h_set = 9'd256;
            end
            2: begin
               w_set = 9'd256;
               h_set = 9'd1;
            end
            3: begin
               w_set = 9'd511;
               h_set = 9'd0;
            end
            4: begin
               w_set = 9'd300;
               h_set = 9'd511;
            end
            default: begin
               w_set = 9'($urandom_range(1, 256));
               h_set = 9'($urandom_range(1, 256));
            end
         endcase
         wait_for_idle();
         write_canvas(CSR_CANVAS_WIDTH, w_set);
         write_canvas(CSR_CANVAS_HEIGHT, h_set);
         req_calm = ($urandom_range(0, 3) == 0);
         rsp_calm = ($urandom_range(0, 3) == 0);
         phase_sent = 0;
         while (phase_sent < ITEMS_PER_PHASE) play_frame(phase_sent);
      end

      wait_for_idle();
      if (bad_writes == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

endmodule
